// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define CSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion that also holds through reset
`define CSC_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== sv/csc_pkg.sv =====
// ---------------------------------------------------------------------------
// Complex sliding correlator package
// Sizes, request codes and shared types of the correlator.
// ---------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

   localparam int MAX_TAPS        = 256;
   localparam int SAMPLE_BITS     = 16;
   localparam int STEP_BITS       = $clog2(MAX_TAPS);
   localparam int CNT_BITS        = STEP_BITS + 1;
   localparam int CSR_BITS        = 9;
   localparam int TAP_COUNT_RESET = 256;
   localparam int IDX_BITS        = 8;
   localparam int ACC_BITS        = 40;
   localparam int LAG_BITS        = 32;
   localparam int PROD_BITS       = 2 * SAMPLE_BITS;
   localparam int SUM_BITS        = PROD_BITS + 1;
   localparam int DRAIN_CYCLES    = 3;
   localparam int DRAIN_BITS      = $clog2(DRAIN_CYCLES + 1);

   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_SAMPLE  = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } sample_type;

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctrl_type;

   typedef struct packed {
      logic                 clear;
      logic                 issue;
      logic [STEP_BITS-1:0] rd_addr;
      logic                 tap_we;
      logic [STEP_BITS-1:0] tap_addr;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/csc_if.sv =====
// ---------------------------------------------------------------------------
// Correlator channel interfaces
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface csc_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [1:0]                               req_type;
   logic [csc_pkg::IDX_BITS-1:0]             tap_index;
   logic signed [csc_pkg::SAMPLE_BITS-1:0]   value_re;
   logic signed [csc_pkg::SAMPLE_BITS-1:0]   value_im;

   modport source (output valid, req_type, tap_index, value_re, value_im, input ready);
   modport sink (input valid, req_type, tap_index, value_re, value_im, output ready);
endinterface

interface csc_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [csc_pkg::ACC_BITS-1:0]      corr_re;
   logic signed [csc_pkg::ACC_BITS-1:0]      corr_im;
   logic [csc_pkg::LAG_BITS-1:0]             lag;

   modport source (output valid, corr_re, corr_im, lag, input ready);
   modport sink (input valid, corr_re, corr_im, lag, output ready);
endinterface

`default_nettype wire

// ===== sv/complex_sliding_correlator_unit.sv =====
// ---------------------------------------------------------------------------
// Complex sliding correlator unit
// Sliding cross-correlation of I/Q samples against conjugated reference taps.
// ---------------------------------------------------------------------------
// A tap load, a restart, an undefined request and a sample that leaves the
// window short of tap_count are each done in the accepting cycle. A sample
// that completes a window covers all MAX_TAPS cells whatever tap_count is:
// the accepting cycle, then the window cell chain rotates once fully past the
// single complex MAC, one window position per cycle, the MAC pipeline drains,
// and the sum moves into the response register once any previous response
// has been taken.
// ---------------------------------------------------------------------------
`default_nettype none

module complex_sliding_correlator_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [csc_pkg::CSR_BITS-1:0]      csr_wdata,
   csc_req_if.sink                          req_bus,
   csc_rsp_if.source                        rsp_bus
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic [csc_pkg::CSR_BITS-1:0]      tap_count_ff;
   logic [csc_pkg::CNT_BITS-1:0]      n_eff;
   logic [csc_pkg::CNT_BITS-1:0]      n_ff, n_in;
   logic [csc_pkg::CNT_BITS-1:0]      fill_ff, fill_in, fill_next;
   logic [csc_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic [csc_pkg::DRAIN_BITS-1:0]    drain_ff, drain_in;
   logic [csc_pkg::LAG_BITS-1:0]      lag_ff, lag_in;
   logic [csc_pkg::LAG_BITS-1:0]      lag_hold_ff, lag_hold_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [csc_pkg::ACC_BITS-1:0] corr_re_ff, corr_im_ff;
   logic [csc_pkg::LAG_BITS-1:0]      lag_out_ff;

   logic accept, is_sample, is_load, is_restart, start, out_load, last_step;

   csc_pkg::sample_type    new_sample, head;
   csc_pkg::cell_ctrl_type cell_ctrl;
   csc_pkg::mac_ctrl_type  mac_ctrl;
   logic signed [csc_pkg::ACC_BITS-1:0] acc_re, acc_im;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_sample     = accept && (req_bus.req_type == csc_pkg::REQ_SAMPLE);
   assign is_load       = accept && (req_bus.req_type == csc_pkg::REQ_LOAD);
   assign is_restart    = accept && (req_bus.req_type == csc_pkg::REQ_RESTART);

   always_comb begin
      priority if (tap_count_ff == '0) begin
         n_eff = csc_pkg::CNT_BITS'(1);
      end else if (32'(tap_count_ff) > 32'(csc_pkg::MAX_TAPS)) begin
         n_eff = csc_pkg::CNT_BITS'(csc_pkg::MAX_TAPS);
      end else begin
         n_eff = csc_pkg::CNT_BITS'(tap_count_ff);
      end
   end

   assign fill_next = (fill_ff < csc_pkg::CNT_BITS'(csc_pkg::MAX_TAPS)) ?
                      fill_ff + csc_pkg::CNT_BITS'(1) : fill_ff;
   assign start     = is_sample && (fill_next >= n_eff);
   assign last_step = (step_ff == csc_pkg::STEP_BITS'(csc_pkg::MAX_TAPS - 1));
   assign out_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      fill_in     = fill_ff;
      step_in     = step_ff;
      drain_in    = drain_ff;
      lag_in      = lag_ff;
      lag_hold_in = lag_hold_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_restart) begin
               fill_in = '0;
               lag_in  = '0;
            end
            if (is_sample) begin
               fill_in = fill_next;
            end
            if (start) begin
               state_in    = ST_RUN;
               n_in        = n_eff;
               step_in     = '0;
               lag_hold_in = lag_ff;
               lag_in      = lag_ff + csc_pkg::LAG_BITS'(1);
            end
         end
         ST_RUN: begin
            step_in = step_ff + csc_pkg::STEP_BITS'(1);
            if (last_step) begin
               state_in = ST_DRAIN;
               drain_in = '0;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + csc_pkg::DRAIN_BITS'(1);
            if (drain_ff == csc_pkg::DRAIN_BITS'(csc_pkg::DRAIN_CYCLES - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_count_ff <= csc_pkg::CSR_BITS'(csc_pkg::TAP_COUNT_RESET);
         fill_ff      <= '0;
         lag_ff       <= '0;
         step_ff      <= '0;
         drain_ff     <= '0;
         n_ff         <= csc_pkg::CNT_BITS'(1);
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            tap_count_ff <= csr_wdata;
         end
         fill_ff      <= fill_in;
         lag_ff       <= lag_in;
         step_ff      <= step_in;
         drain_ff     <= drain_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      lag_hold_ff <= lag_hold_in;
   end

   assign new_sample.re    = req_bus.value_re;
   assign new_sample.im    = req_bus.value_im;
   assign cell_ctrl.shift  = is_sample;
   assign cell_ctrl.rotate = (state_ff == ST_RUN);

   assign mac_ctrl.clear    = start;
   assign mac_ctrl.issue    = (state_ff == ST_RUN) &&
                              ({1'b0, step_ff} < n_ff);
   assign mac_ctrl.rd_addr  = csc_pkg::STEP_BITS'(n_ff - csc_pkg::CNT_BITS'(1) -
                                                  {1'b0, step_ff});
   assign mac_ctrl.tap_we   = is_load &&
                              (32'(req_bus.tap_index) < 32'(csc_pkg::MAX_TAPS));
   assign mac_ctrl.tap_addr = csc_pkg::STEP_BITS'(req_bus.tap_index);

   csc_window u_window (
      .clock      (clock),
      .ctrl       (cell_ctrl),
      .new_sample (new_sample),
      .head       (head)
   );

   csc_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .tap_wdata (new_sample),
      .head      (head),
      .acc_re    (acc_re),
      .acc_im    (acc_im)
   );

   // hold the response until taken
   always_comb begin
      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         corr_re_ff <= acc_re;
         corr_im_ff <= acc_im;
         lag_out_ff <= lag_hold_ff;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.corr_re = corr_re_ff;
   assign rsp_bus.corr_im = corr_im_ff;
   assign rsp_bus.lag     = lag_out_ff;

endmodule

`default_nettype wire

// ===== sv/csc_cell.sv =====
// ---------------------------------------------------------------------------
// Correlator window cell
// Holds one window sample; loads from the newer-side neighbour on a shift
// and from the older-side neighbour on a rotation.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_cell (
   input  wire                    clock,
   input  csc_pkg::cell_ctrl_type ctrl,
   input  csc_pkg::sample_type    shift_in,
   input  csc_pkg::sample_type    rot_in,
   output csc_pkg::sample_type    value
);

   csc_pkg::sample_type sample_ff;
   csc_pkg::sample_type sample_in;

   always_comb begin
      priority if (ctrl.shift) begin
         sample_in = shift_in;
      end else if (ctrl.rotate) begin
         sample_in = rot_in;
      end else begin
         sample_in = sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign value = sample_ff;

endmodule

`default_nettype wire

// ===== sv/csc_window.sv =====
// ---------------------------------------------------------------------------
// Correlator window chain
// Row of window cells; cell 0 holds the newest sample and is the read head.
// A rotation moves every sample one cell towards the head, wrapping round.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_window (
   input  wire                    clock,
   input  csc_pkg::cell_ctrl_type ctrl,
   input  csc_pkg::sample_type    new_sample,
   output csc_pkg::sample_type    head
);

   csc_pkg::sample_type cell_value [csc_pkg::MAX_TAPS];

   for (genvar k = 0; k < csc_pkg::MAX_TAPS; k++) begin : g_cell
      csc_pkg::sample_type shift_src;
      csc_pkg::sample_type rot_src;

      if (k == 0) begin : g_first
         assign shift_src = new_sample;
      end else begin : g_rest
         assign shift_src = cell_value[k-1];
      end

      if (k == csc_pkg::MAX_TAPS - 1) begin : g_last
         assign rot_src = cell_value[0];
      end else begin : g_inner
         assign rot_src = cell_value[k+1];
      end

      csc_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .shift_in (shift_src),
         .rot_in   (rot_src),
         .value    (cell_value[k])
      );
   end

   assign head = cell_value[0];

endmodule

`default_nettype wire

// ===== sv/csc_mac.sv =====
// ---------------------------------------------------------------------------
// Correlator multiply-accumulate
// Reference tap store and one complex conjugate MAC: tap read, four
// products, pair sums, 40-bit accumulation.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_mac (
   input  wire                                  clock,
   input  wire                                  reset,
   input  csc_pkg::mac_ctrl_type                ctrl,
   input  csc_pkg::sample_type                  tap_wdata,
   input  csc_pkg::sample_type                  head,
   output logic signed [csc_pkg::ACC_BITS-1:0]  acc_re,
   output logic signed [csc_pkg::ACC_BITS-1:0]  acc_im
);

   csc_pkg::sample_type tap_mem [csc_pkg::MAX_TAPS];

   csc_pkg::sample_type tap_ff;
   csc_pkg::sample_type x_ff;
   logic                v1_ff;

   logic signed [csc_pkg::PROD_BITS-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic signed [csc_pkg::PROD_BITS-1:0] p_rr_in, p_ii_in, p_ir_in, p_ri_in;
   logic                                 v2_ff;

   logic signed [csc_pkg::SUM_BITS-1:0]  sum_re_ff, sum_im_ff;
   logic signed [csc_pkg::SUM_BITS-1:0]  sum_re_in, sum_im_in;
   logic                                 v3_ff;

   logic signed [csc_pkg::ACC_BITS-1:0]  acc_re_ff, acc_im_ff;
   logic signed [csc_pkg::ACC_BITS-1:0]  acc_re_in, acc_im_in;

   always_ff @(posedge clock) begin
      if (ctrl.tap_we) begin
         tap_mem[ctrl.tap_addr] <= tap_wdata;
      end
      tap_ff <= tap_mem[ctrl.rd_addr];
   end

   always_comb begin
      p_rr_in = x_ff.re * tap_ff.re;
      p_ii_in = x_ff.im * tap_ff.im;
      p_ir_in = x_ff.re * tap_ff.im;
      p_ri_in = x_ff.im * tap_ff.re;
      // conjugated tap: re = xr.rr + xi.ri, im = xi.rr - xr.ri
      sum_re_in = csc_pkg::SUM_BITS'(p_rr_ff) + csc_pkg::SUM_BITS'(p_ii_ff);
      sum_im_in = csc_pkg::SUM_BITS'(p_ri_ff) - csc_pkg::SUM_BITS'(p_ir_ff);
      priority if (ctrl.clear) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (v3_ff) begin
         acc_re_in = acc_re_ff + csc_pkg::ACC_BITS'(sum_re_ff);
         acc_im_in = acc_im_ff + csc_pkg::ACC_BITS'(sum_im_ff);
      end else begin
         acc_re_in = acc_re_ff;
         acc_im_in = acc_im_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= head;
      p_rr_ff   <= p_rr_in;
      p_ii_ff   <= p_ii_in;
      p_ir_ff   <= p_ir_in;
      p_ri_ff   <= p_ri_in;
      sum_re_ff <= sum_re_in;
      sum_im_ff <= sum_im_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= ctrl.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;

endmodule

`default_nettype wire

// ===== sv/csc_checker.sv =====
// ---------------------------------------------------------------------------
// Correlator port checker
// Watches the correlator ports over time; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module csc_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_ready,
   input wire [1:0]                        req_type,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire [csc_pkg::ACC_BITS-1:0]      corr_re,
   input wire [csc_pkg::ACC_BITS-1:0]      corr_im,
   input wire [csc_pkg::LAG_BITS-1:0]      lag
);

   logic [2*csc_pkg::ACC_BITS+csc_pkg::LAG_BITS-1:0] rsp_payload;
   logic                                              non_sample_accept;

   assign rsp_payload       = {corr_re, corr_im, lag};
   assign non_sample_accept = req_valid && req_ready && (req_type != csc_pkg::REQ_SAMPLE);

   `CSC_ASSERT_NR(a_reset_drops_rsp, clock, reset |=> !rsp_valid)

   `CSC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

   `CSC_ASSERT(a_non_sample_one_cycle, clock, reset, non_sample_accept |=> req_ready)

   `CSC_ASSERT(a_rsp_after_busy, clock, reset, $rose(rsp_valid) |-> $past(!req_ready))

endmodule

bind complex_sliding_correlator_unit csc_checker u_csc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_type  (req_bus.req_type),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .corr_re   (rsp_bus.corr_re),
   .corr_im   (rsp_bus.corr_im),
   .lag       (rsp_bus.lag)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// Complex sliding correlator testbench
// Drives tap loads, samples, restarts and undefined requests through the
// request channel and changes the tap count between phases. Each transaction
// is fed to an in-bench correlator that predicts every response field. The
// random part shifts in random I/Q data with bursty sending and patterned
// response back-pressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import csc_pkg::*;

   localparam logic [1:0] REQ_UNDEFINED = 2'd3;
   localparam logic [SAMPLE_BITS-1:0] Q15_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] Q15_MAX = ~Q15_MIN;
   localparam int MIN_RESULTS = 24;

   typedef struct {
      logic [ACC_BITS-1:0] re;
      logic [ACC_BITS-1:0] im;
      logic [LAG_BITS-1:0] lag;
   } corr_rec_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_BITS-1:0]  csr_wdata;

   csc_req_if req_if ();
   csc_rsp_if rsp_if ();

   complex_sliding_correlator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if)
   );

   // predicted correlator state
   sample_type           tap_mem [MAX_TAPS];
   sample_type           win_mem [MAX_TAPS];
   int unsigned          win_fill;
   logic [LAG_BITS-1:0]  next_lag;
   logic [CSR_BITS-1:0]  tap_count_reg;

   corr_rec_type         corr_pending [$];
   corr_rec_type         corr_head;
   int unsigned          corr_predicted;
   int unsigned          error_count;
   int unsigned          burst_left;
   int                   stall_count;
   logic [15:0]          stall_mask;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int unsigned effective_taps();
      if (tap_count_reg == '0)
         return 1;
      if (32'(tap_count_reg) > MAX_TAPS)
         return MAX_TAPS;
      return 32'(tap_count_reg);
   endfunction

   function automatic void correlate_request(input logic [1:0] kind,
                                             input logic [IDX_BITS-1:0] idx,
                                             input logic [SAMPLE_BITS-1:0] val_re,
                                             input logic [SAMPLE_BITS-1:0] val_im);
      int unsigned n;
      longint acc_re;
      longint acc_im;
      sample_type x;
      sample_type r;
      corr_rec_type rec;
      case (kind)
         REQ_LOAD: begin
            tap_mem[idx] = '{re: val_re, im: val_im};
         end
         REQ_RESTART: begin
            win_fill = 0;
            next_lag = '0;
         end
         REQ_SAMPLE: begin
            for (int k = MAX_TAPS - 1; k > 0; k--)
               win_mem[k] = win_mem[k-1];
            win_mem[0] = '{re: val_re, im: val_im};
            if (win_fill < MAX_TAPS)
               win_fill++;
            n = effective_taps();
            if (win_fill >= n) begin
               acc_re = 0;
               acc_im = 0;
               for (int j = 0; j < n; j++) begin
                  x = win_mem[n-1-j];
                  r = tap_mem[j];
                  acc_re += longint'($signed(x.re)) * longint'($signed(r.re))
                          + longint'($signed(x.im)) * longint'($signed(r.im));
                  acc_im += longint'($signed(x.im)) * longint'($signed(r.re))
                          - longint'($signed(x.re)) * longint'($signed(r.im));
               end
               rec.re  = acc_re[ACC_BITS-1:0];
               rec.im  = acc_im[ACC_BITS-1:0];
               rec.lag = next_lag;
               corr_pending.push_back(rec);
               next_lag++;
               corr_predicted++;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_q15();
      case ($urandom_range(7, 0))
         0:       return Q15_MIN;
         1:       return Q15_MAX;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [63:0] expected,
                                       input logic [63:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                  expected, actual);
         error_count++;
      end
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [IDX_BITS-1:0] idx,
                               input logic [SAMPLE_BITS-1:0] val_re,
                               input logic [SAMPLE_BITS-1:0] val_im);
      int gap;
      req_if.valid     <= 1'b1;
      req_if.req_type  <= kind;
      req_if.tap_index <= idx;
      req_if.value_re  <= val_re;
      req_if.value_im  <= val_im;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      correlate_request(kind, idx, val_re, val_im);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(12, 0);
         gap = $urandom_range(5, 1);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, wait for every response, then let the block go quiet
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (corr_pending.size() != 0)
         @(posedge clock);
      repeat (MAX_TAPS + 8) @(posedge clock);
   endtask

   task automatic write_tap_count(input logic [CSR_BITS-1:0] value);
      settle_block();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      tap_count_reg = value;
      csr_we <= 1'b0;
   endtask

   task automatic test_full_scale();
      write_tap_count('1);
      for (int k = 0; k < MAX_TAPS; k++)
         send_request(REQ_LOAD, IDX_BITS'(k), Q15_MIN, Q15_MIN);
      for (int k = 0; k < MAX_TAPS + 2; k++)
         send_request(REQ_SAMPLE, IDX_BITS'($urandom), Q15_MIN, Q15_MIN);
   endtask

   task automatic test_load_reference();
      for (int k = 0; k < MAX_TAPS; k++)
         send_request(REQ_LOAD, IDX_BITS'(k), pick_q15(), pick_q15());
   endtask

   task automatic test_short_windows();
      write_tap_count(CSR_BITS'(1));
      send_request(REQ_SAMPLE, '0, Q15_MIN, Q15_MIN);
      send_request(REQ_SAMPLE, '1, Q15_MAX, Q15_MAX);
      send_request(REQ_SAMPLE, '0, Q15_MAX, Q15_MIN);
      send_request(REQ_SAMPLE, '1, Q15_MIN, Q15_MAX);
      send_request(REQ_SAMPLE, '0, '0, '0);
      send_request(REQ_UNDEFINED, '1, Q15_MIN, Q15_MAX);
      send_request(REQ_RESTART, '1, Q15_MAX, Q15_MIN);
      send_request(REQ_SAMPLE, IDX_BITS'($urandom), pick_q15(), pick_q15());
      send_request(REQ_LOAD, '0, Q15_MIN, Q15_MAX);
      send_request(REQ_SAMPLE, '0, Q15_MIN, Q15_MIN);
      write_tap_count('0);
      send_request(REQ_SAMPLE, '0, Q15_MAX, Q15_MIN);
      send_request(REQ_SAMPLE, '0, pick_q15(), pick_q15());
   endtask

   // shorten the window after a partial fill, without a restart
   task automatic test_retune();
      write_tap_count(CSR_BITS'(5));
      send_request(REQ_RESTART, '0, '0, '0);
      repeat (4) send_request(REQ_SAMPLE, IDX_BITS'($urandom), pick_q15(), pick_q15());
      write_tap_count(CSR_BITS'(3));
      repeat (2) send_request(REQ_SAMPLE, IDX_BITS'($urandom), pick_q15(), pick_q15());
   endtask

   task automatic test_random_traffic(input logic [CSR_BITS-1:0] count_value,
                                      input int unsigned quota);
      int unsigned sent;
      int unsigned first_result;
      int unsigned n_eff;
      int pick;
      logic [1:0] kind;
      write_tap_count(count_value);
      n_eff = effective_taps();
      sent = 0;
      first_result = corr_predicted;
      while (sent < quota || corr_predicted - first_result < MIN_RESULTS) begin
         pick = $urandom_range(99, 0);
         if ($urandom_range(8 * n_eff + 32, 0) == 0)
            kind = REQ_RESTART;
         else if (pick < 85)
            kind = REQ_SAMPLE;
         else if (pick < 96)
            kind = REQ_LOAD;
         else
            kind = REQ_UNDEFINED;
         send_request(kind, IDX_BITS'($urandom), pick_q15(), pick_q15());
         if (kind != REQ_UNDEFINED)
            sent++;
      end
   endtask

   // response back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      stall_count  = 0;
      stall_mask   = '1;
      forever begin
         @(posedge clock);
         if (stall_count == 0) begin
            stall_count = $urandom_range(250, 30);
            stall_mask  = ($urandom_range(3, 0) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
         end else begin
            stall_count--;
         end
         rsp_if.ready <= stall_mask[stall_count[3:0]];
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
         if (corr_pending.size() == 0) begin
            $display("%0t: response with none expected, actual %0h %0h lag %0h", $time,
                     rsp_if.corr_re, rsp_if.corr_im, rsp_if.lag);
            error_count++;
         end else begin
            corr_head = corr_pending.pop_front();
            check_field("corr_re", corr_head.re, $unsigned(rsp_if.corr_re));
            check_field("corr_im", corr_head.im, $unsigned(rsp_if.corr_im));
            check_field("lag", corr_head.lag, rsp_if.lag);
         end
      end
   end

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.req_type  = REQ_LOAD;
      req_if.tap_index = '0;
      req_if.value_re  = '0;
      req_if.value_im  = '0;
      for (int k = 0; k < MAX_TAPS; k++) begin
         tap_mem[k] = '0;
         win_mem[k] = '0;
      end
      win_fill       = 0;
      next_lag       = '0;
      tap_count_reg  = CSR_BITS'(TAP_COUNT_RESET);
      corr_predicted = 0;
      error_count    = 0;
      burst_left     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_full_scale();
      test_load_reference();
      test_short_windows();
      test_retune();
      test_random_traffic(CSR_BITS'(2), 70);
      test_random_traffic(CSR_BITS'(9), 70);
      test_random_traffic(CSR_BITS'(33), 70);
      test_random_traffic(CSR_BITS'(128), 70);
      test_random_traffic(CSR_BITS'(MAX_TAPS), 70);
      test_random_traffic(CSR_BITS'(400), 70);
      test_random_traffic(CSR_BITS'($urandom_range(MAX_TAPS - 1, 1)), 70);
      test_random_traffic(CSR_BITS'(1), 70);
      settle_block();

      if (error_count == 0 && corr_pending.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
